// ----- rtl/gcbm_pkg.sv -----
// ============================================================================
// gcbm_pkg
// Types, constants and the source selection table shared by the mapper.
// ============================================================================
package gcbm_pkg;

    localparam int PORT_COUNT = 4;
    localparam int HOLD_READS = 8;

    localparam int PORT_AW = (PORT_COUNT > 1) ? $clog2(PORT_COUNT) : 1;
    localparam int HOLD_W  = 4;
    localparam int CFG_AW  = 6;
    localparam int CFG_DW  = 64;

    localparam logic [34:0] MAP_A_RESET   = 35'd8764132417;
    localparam logic [34:0] MAP_B_RESET   = 35'd22131817899;
    localparam logic [23:0] EXIT_RESET    = 24'd144;
    localparam logic [6:0]  DEADZONE_RST  = 7'd18;
    localparam logic [31:0] STICKS_CENTRE = 32'h8080_8080;

    typedef logic [PORT_AW-1:0] t_addr;

    typedef enum logic [2:0] {
        REG_MAP_A     = 3'd0,
        REG_MAP_B     = 3'd1,
        REG_ANALOG    = 3'd2,
        REG_INVERT_Y  = 3'd3,
        REG_EXIT_MASK = 3'd4,
        REG_DEADZONE  = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic [1:0]  port;
        logic        connected;
        logic        new_report;
        logic [15:0] pad_buttons;
        logic [31:0] pad_sticks;
    } t_in;

    typedef struct packed {
        logic [13:0]        console_buttons;
        logic signed [7:0]  x_axis;
        logic signed [7:0]  y_axis;
        logic               exit_pressed;
    } t_out;

    typedef struct packed {
        logic [15:0]       buttons;
        logic [31:0]       sticks;
        logic [15:0]       latched;
        logic [HOLD_W-1:0] hold_left;
    } t_entry;

    localparam t_entry ENTRY_RESET = '{
        buttons:   16'h0000,
        sticks:    STICKS_CENTRE,
        latched:   16'h0000,
        hold_left: '0
    };

    typedef struct packed {
        logic [34:0] map_a;
        logic [34:0] map_b;
        logic        analog_source;
        logic        invert_y;
        logic [23:0] exit_mask;
        logic [6:0]  deadzone;
    } t_cfg;

    // Returns the source bit chosen by a 5-bit index; unused indices read zero.
    function automatic logic pick_source(input logic [23:0] src, input logic [4:0] idx);
        case (idx)
            5'd1:    return src[12];
            5'd2:    return src[15];
            5'd3:    return src[13];
            5'd4:    return src[14];
            5'd5:    return src[2];
            5'd6:    return src[0];
            5'd7:    return src[9];
            5'd8:    return src[3];
            5'd9:    return src[1];
            5'd10:   return src[10];
            5'd11:   return src[6];
            5'd12:   return src[7];
            5'd13:   return src[5];
            5'd14:   return src[4];
            5'd15:   return src[11];
            5'd16:   return src[8];
            5'd17:   return src[22];
            5'd18:   return src[20];
            5'd19:   return src[21];
            5'd20:   return src[23];
            5'd21:   return src[18];
            5'd22:   return src[16];
            5'd23:   return src[17];
            5'd24:   return src[19];
            default: return 1'b0;
        endcase
    endfunction

endpackage

// ----- rtl/gcbm_cfg.sv -----
// ============================================================================
// gcbm_cfg
// Configuration register file behind the APB-style port.
// ============================================================================
module gcbm_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [gcbm_pkg::CFG_AW-1:0]   paddr,
    input  logic [gcbm_pkg::CFG_DW-1:0]   pwdata,
    output logic [gcbm_pkg::CFG_DW-1:0]   prdata,
    output logic                          pready,
    output gcbm_pkg::t_cfg                o_cfg
);

    gcbm_pkg::t_cfg r_cfg;
    logic           wr_hit;
    logic [2:0]     reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[5:3];
    assign wr_hit  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.map_a         <= gcbm_pkg::MAP_A_RESET;
            r_cfg.map_b         <= gcbm_pkg::MAP_B_RESET;
            r_cfg.analog_source <= 1'b0;
            r_cfg.invert_y      <= 1'b0;
            r_cfg.exit_mask     <= gcbm_pkg::EXIT_RESET;
            r_cfg.deadzone      <= gcbm_pkg::DEADZONE_RST;
        end else if (wr_hit) begin
            case (reg_idx)
                gcbm_pkg::REG_MAP_A:     r_cfg.map_a         <= pwdata[34:0];
                gcbm_pkg::REG_MAP_B:     r_cfg.map_b         <= pwdata[34:0];
                gcbm_pkg::REG_ANALOG:    r_cfg.analog_source <= pwdata[0];
                gcbm_pkg::REG_INVERT_Y:  r_cfg.invert_y      <= pwdata[0];
                gcbm_pkg::REG_EXIT_MASK: r_cfg.exit_mask     <= pwdata[23:0];
                gcbm_pkg::REG_DEADZONE:  r_cfg.deadzone      <= pwdata[6:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            gcbm_pkg::REG_MAP_A:     prdata = {29'd0, r_cfg.map_a};
            gcbm_pkg::REG_MAP_B:     prdata = {29'd0, r_cfg.map_b};
            gcbm_pkg::REG_ANALOG:    prdata = {63'd0, r_cfg.analog_source};
            gcbm_pkg::REG_INVERT_Y:  prdata = {63'd0, r_cfg.invert_y};
            gcbm_pkg::REG_EXIT_MASK: prdata = {40'd0, r_cfg.exit_mask};
            gcbm_pkg::REG_DEADZONE:  prdata = {57'd0, r_cfg.deadzone};
            default:                 prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

// ----- rtl/gcbm_state_mem.sv -----
// ============================================================================
// gcbm_state_mem
// Per-port state memory with registered read, valid bits and write forwarding.
// ============================================================================
module gcbm_state_mem (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_rd_en,
    input  gcbm_pkg::t_addr      i_rd_addr,
    input  logic                 i_wr_en,
    input  gcbm_pkg::t_addr      i_wr_addr,
    input  gcbm_pkg::t_entry     i_wr_data,
    output gcbm_pkg::t_entry     o_rd_data
);

    gcbm_pkg::t_entry                  r_mem [gcbm_pkg::PORT_COUNT];
    logic [gcbm_pkg::PORT_COUNT-1:0]   r_vld;
    gcbm_pkg::t_entry                  r_rd_data;
    logic                              r_rd_vld;
    logic                              r_fwd;
    gcbm_pkg::t_entry                  r_fwd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data  <= r_mem[i_rd_addr];
            r_fwd_data <= i_wr_data;
        end
    end

    // A write landing on the entry being read in the same cycle is forwarded,
    // since the array read returns the old contents.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
            r_fwd    <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_vld <= r_vld[i_rd_addr];
                r_fwd    <= i_wr_en && (i_wr_addr == i_rd_addr);
            end
        end
    end

    assign o_rd_data = r_fwd    ? r_fwd_data :
                       r_rd_vld ? r_rd_data  : gcbm_pkg::ENTRY_RESET;

endmodule

// ----- rtl/gcbm_map.sv -----
// ============================================================================
// gcbm_map
// State update, stick centring, direction bits and console button selection.
// ============================================================================
module gcbm_map (
    input  gcbm_pkg::t_in     i_item,
    input  gcbm_pkg::t_entry  i_entry,
    input  gcbm_pkg::t_cfg    i_cfg,
    output logic              o_wr_en,
    output gcbm_pkg::t_entry  o_entry,
    output gcbm_pkg::t_out    o_result
);

    logic              active;
    logic [15:0]       newly;
    logic [15:0]       btn;
    logic [23:0]       src;
    gcbm_pkg::t_entry  ent;
    logic signed [7:0] lx, ly, rx, ry, ox, oy;
    logic signed [8:0] lx9, ly9, rx9, ry9, dz9, ndz9;
    logic [13:0]       cons;

    always_comb begin
        active = i_item.connected && (int'(i_item.port) < gcbm_pkg::PORT_COUNT);
        newly  = i_item.pad_buttons & ~i_entry.latched;
        ent    = i_entry;
        if (i_item.new_report) begin
            ent.buttons = i_item.pad_buttons;
            ent.sticks  = i_item.pad_sticks;
            ent.latched = i_item.pad_buttons;
            if (newly != 16'h0000) begin
                ent.hold_left = gcbm_pkg::HOLD_W'(gcbm_pkg::HOLD_READS);
            end
        end

        btn = ent.buttons;
        if (ent.hold_left != '0) begin
            btn           = btn | ent.latched;
            ent.hold_left = ent.hold_left - 1'b1;
        end

        // Byte minus 128 is the byte with its top bit flipped. Y is negated,
        // with the one value that has no negation pinned to the top.
        lx = {~ent.sticks[15], ent.sticks[14:8]};
        rx = {~ent.sticks[31], ent.sticks[30:24]};
        ly = (ent.sticks[7:0] == 8'h00) ? 8'sd127
                                        : -$signed({~ent.sticks[7], ent.sticks[6:0]});
        ry = (ent.sticks[23:16] == 8'h00) ? 8'sd127
                                          : -$signed({~ent.sticks[23], ent.sticks[22:16]});

        lx9  = {lx[7], lx};
        ly9  = {ly[7], ly};
        rx9  = {rx[7], rx};
        ry9  = {ry[7], ry};
        dz9  = $signed({2'b00, i_cfg.deadzone});
        ndz9 = -dz9;

        src = {ry9 > dz9, ry9 < ndz9, rx9 > dz9, rx9 < ndz9,
               ly9 > dz9, ly9 < ndz9, lx9 > dz9, lx9 < ndz9, btn};

        cons[0]  = gcbm_pkg::pick_source(src, i_cfg.map_a[14:10]);
        cons[1]  = gcbm_pkg::pick_source(src, i_cfg.map_a[9:5]);
        cons[2]  = gcbm_pkg::pick_source(src, i_cfg.map_a[19:15]);
        cons[3]  = gcbm_pkg::pick_source(src, i_cfg.map_a[4:0]);
        cons[4]  = gcbm_pkg::pick_source(src, i_cfg.map_b[14:10]);
        cons[5]  = gcbm_pkg::pick_source(src, i_cfg.map_b[9:5]);
        cons[6]  = gcbm_pkg::pick_source(src, i_cfg.map_b[4:0]);
        cons[7]  = gcbm_pkg::pick_source(src, i_cfg.map_a[24:20]);
        cons[8]  = gcbm_pkg::pick_source(src, i_cfg.map_a[34:30]);
        cons[9]  = gcbm_pkg::pick_source(src, i_cfg.map_a[29:25]);
        cons[10] = gcbm_pkg::pick_source(src, i_cfg.map_b[29:25]);
        cons[11] = gcbm_pkg::pick_source(src, i_cfg.map_b[24:20]);
        cons[12] = gcbm_pkg::pick_source(src, i_cfg.map_b[34:30]);
        cons[13] = gcbm_pkg::pick_source(src, i_cfg.map_b[19:15]);

        ox = i_cfg.analog_source ? rx : lx;
        oy = i_cfg.analog_source ? ry : ly;
        if (i_cfg.invert_y) begin
            oy = -oy;
        end

        o_wr_en = active;
        o_entry = ent;
        if (active) begin
            o_result.console_buttons = cons;
            o_result.x_axis          = ox;
            o_result.y_axis          = oy;
            o_result.exit_pressed    = ((src & i_cfg.exit_mask) == i_cfg.exit_mask);
        end else begin
            o_result = '0;
        end
    end

endmodule

// ----- rtl/gamepad_to_console_button_mapper.sv -----
// ============================================================================
// gamepad_to_console_button_mapper
// Maps pad reports to console buttons and stick axes, with per-port state.
// ============================================================================
//
//  channel   direction  handshake                  payload
//  in        input      i_in_valid / o_in_stall    i_in_data  (t_in)
//  out       output     o_out_valid / i_out_stall  o_out_data (t_out)
//  cfg       input      psel penable pwrite pready paddr, pwdata / prdata
//
//  One item is accepted per cycle while o_in_stall is low. The accepting edge reads
//  the state memory into the middle stage; the result is mapped from there and
//  loaded into the output register once that register can take it. Back-to-back
//  items on the same port are served by forwarding the write-back. State entries
//  read as their reset values until written. A stall on the output holds the output
//  register and, once the middle stage is full too, stalls the input.
//
module gamepad_to_console_button_mapper (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  gcbm_pkg::t_in                 i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output gcbm_pkg::t_out                o_out_data,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [gcbm_pkg::CFG_AW-1:0]   paddr,
    input  logic [gcbm_pkg::CFG_DW-1:0]   pwdata,
    output logic [gcbm_pkg::CFG_DW-1:0]   prdata,
    output logic                          pready
);

    gcbm_pkg::t_cfg    cfg;
    gcbm_pkg::t_entry  rd_entry;
    gcbm_pkg::t_entry  wr_entry;
    gcbm_pkg::t_out    result;
    logic              map_wr;
    logic              accept;
    logic              s1_adv;
    logic              rd_en;
    logic              wr_en;

    logic              r_s1_vld;
    gcbm_pkg::t_in     r_s1_item;
    logic              r_out_vld;
    gcbm_pkg::t_out    r_out;

    assign s1_adv     = !r_out_vld || !i_out_stall;
    assign o_in_stall = r_s1_vld && !s1_adv;
    assign accept     = i_in_valid && !o_in_stall;
    assign rd_en      = accept && (int'(i_in_data.port) < gcbm_pkg::PORT_COUNT);
    assign wr_en      = r_s1_vld && s1_adv && map_wr;

    gcbm_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    gcbm_state_mem u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (rd_en),
        .i_rd_addr (gcbm_pkg::t_addr'(i_in_data.port)),
        .i_wr_en   (wr_en),
        .i_wr_addr (gcbm_pkg::t_addr'(r_s1_item.port)),
        .i_wr_data (wr_entry),
        .o_rd_data (rd_entry)
    );

    gcbm_map u_map (
        .i_item   (r_s1_item),
        .i_entry  (rd_entry),
        .i_cfg    (cfg),
        .o_wr_en  (map_wr),
        .o_entry  (wr_entry),
        .o_result (result)
    );

    // The middle stage loads whenever it is empty or moving on, even while the
    // output register is held.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (!o_in_stall) begin
                r_s1_vld <= accept;
            end
            if (s1_adv) begin
                r_out_vld <= r_s1_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_item <= i_in_data;
        end
        if (s1_adv && r_s1_vld) begin
            r_out <= result;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

`ifndef SYNTHESIS
    a_idle_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

    a_unconnected_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_vld && s1_adv && !r_s1_item.connected |=> o_out_valid && (o_out_data == '0))
        else $error("item from an absent pad gave a nonzero result");

    a_hold_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> (wr_entry.hold_left < gcbm_pkg::HOLD_W'(gcbm_pkg::HOLD_READS)))
        else $error("hold count written back above its reload value");
`endif

endmodule
